// File: hdl/lps_pkg.sv
// Lane position smoother: shared types and constants.
// No dependencies.
package lps_pkg;

	localparam int XW = 12;  // x coordinate width

	typedef struct packed {
		logic [XW-1:0] left_top_x;
		logic [XW-1:0] left_bottom_x;
		logic [XW-1:0] right_top_x;
		logic [XW-1:0] right_bottom_x;
	} lps_in_t;

	typedef struct packed {
		logic          show_lanes;
		logic          history_cleared;
		logic [XW-1:0] avg_left_top;
		logic [XW-1:0] avg_left_bottom;
		logic [XW-1:0] avg_right_top;
		logic [XW-1:0] avg_right_bottom;
	} lps_out_t;

endpackage

// File: hdl/lps_stream_if.sv
// Valid/ready stream interface carrying one payload item per handshake.
// Payload type is a parameter; no other dependencies.
interface lps_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/lane_position_smoother_core.sv
// Lane position smoother top level: history RAMs, summing sequencer, shared divider.
// Depends on lps_pkg, lps_stream_if and lps_ram.
//
//  port      dir   item       payload
//  lanes     in    lps_in_t   four lane x positions of one frame
//  smoothed  out   lps_out_t  show/cleared flags and four averages
//
// One item goes through accept, push, history scan, four divisions and result write;
// each division runs over an SW-bit dividend, SW = 12 + clog2(D+1).
// A side with no counted entries skips its two divisions.
// The shared restoring divider makes one quotient bit per cycle.
// Reset clears fill counts, pointers, miss state and the output valid; RAM contents
// are never cleared, entries past the fill count are ignored.
// lanes.ready is high only between items; a finished result waits in the output
// register and the next item may be taken meanwhile. A new result stalls while it is full.
module lane_position_smoother_core
	import lps_pkg::*;
#(
	parameter int HISTORY_DEPTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	lps_stream_if.sink   lanes,
	lps_stream_if.source smoothed
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int SW = XW + CW;
	localparam int BW = $clog2(SW);
	localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(HISTORY_DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_SUM,
		S_DLOAD,
		S_DIV,
		S_DONE
	} state_t;

	state_t          state_q;
	lps_in_t         in_q;
	lps_out_t        out_q;
	logic            out_vld_q;

	logic [AW-1:0]   ptr_l_q, ptr_r_q;
	logic [CW-1:0]   cnt_l_q, cnt_r_q;
	logic [CW-1:0]   miss_q;
	logic            long_miss_q;
	logic            show_q, clear_q;

	logic [CW-1:0]   idx_q;
	logic            pend_l_q, pend_r_q;
	logic [SW-1:0]   st_l_q, sb_l_q, st_r_q, sb_r_q;
	logic [CW-1:0]   n_l_q, n_r_q;

	logic [1:0]      div_idx_q;
	logic [BW-1:0]   bit_q;
	logic [SW-1:0]   quo_q;
	logic [CW-1:0]   rem_q;
	logic [CW-1:0]   dvs_q;
	logic [XW-1:0]   avg_q [4];

	// history RAM ports
	logic            left_on, right_on;
	logic            we_l, we_r;
	logic [2*XW-1:0] rd_l, rd_r;

	assign left_on  = (in_q.left_top_x != '0) || (in_q.left_bottom_x != '0);
	assign right_on = (in_q.right_top_x != '0) || (in_q.right_bottom_x != '0);
	assign we_l     = (state_q == S_PUSH) && left_on;
	assign we_r     = (state_q == S_PUSH) && right_on;

	lps_ram #(.WIDTH(2 * XW), .DEPTH(HISTORY_DEPTH)) u_ram_l (
		.clk   (clk),
		.we    (we_l),
		.waddr (ptr_l_q),
		.wdata ({in_q.left_top_x, in_q.left_bottom_x}),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_l)
	);

	lps_ram #(.WIDTH(2 * XW), .DEPTH(HISTORY_DEPTH)) u_ram_r (
		.clk   (clk),
		.we    (we_r),
		.waddr (ptr_r_q),
		.wdata ({in_q.right_top_x, in_q.right_bottom_x}),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_r)
	);

	// miss bookkeeping for the current item
	logic            both_on, none_on, ended;
	logic [CW-1:0]   miss_nx;

	assign both_on = left_on && right_on;
	assign none_on = !left_on && !right_on;
	assign ended   = both_on && long_miss_q;

	always_comb begin
		if (both_on) begin
			miss_nx = '0;
		end else if (none_on && (miss_q < DEPTH_C)) begin
			miss_nx = miss_q + 1'b1;
		end else begin
			miss_nx = miss_q;
		end
	end

	// divider operand select and restoring step
	logic [SW-1:0]   dvd_sel;
	logic [CW-1:0]   dvs_sel;
	logic [CW:0]     rem_sh, diff;
	logic            ge;
	logic [CW-1:0]   rem_nx;
	logic [SW-1:0]   quo_nx;

	always_comb begin
		case (div_idx_q)
			2'd0:    begin dvd_sel = st_l_q; dvs_sel = n_l_q; end
			2'd1:    begin dvd_sel = sb_l_q; dvs_sel = n_l_q; end
			2'd2:    begin dvd_sel = st_r_q; dvs_sel = n_r_q; end
			default: begin dvd_sel = sb_r_q; dvs_sel = n_r_q; end
		endcase
	end

	assign rem_sh = {rem_q, quo_q[SW-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign ge     = !diff[CW];
	assign rem_nx = ge ? diff[CW-1:0] : rem_sh[CW-1:0];
	assign quo_nx = {quo_q[SW-2:0], ge};

	logic out_free;
	assign out_free = !out_vld_q || smoothed.ready;

	assign lanes.ready    = (state_q == S_IDLE);
	assign smoothed.valid = out_vld_q;
	assign smoothed.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_vld_q   <= 1'b0;
			ptr_l_q     <= '0;
			ptr_r_q     <= '0;
			cnt_l_q     <= '0;
			cnt_r_q     <= '0;
			miss_q      <= '0;
			long_miss_q <= 1'b0;
			pend_l_q    <= 1'b0;
			pend_r_q    <= 1'b0;
			idx_q       <= '0;
			div_idx_q   <= '0;
			bit_q       <= '0;
		end else begin
			// S_DONE reloads the output register itself
			if (out_vld_q && smoothed.ready && (state_q != S_DONE)) begin
				out_vld_q <= 1'b0;
			end

			// read data arrives in the cycle after the address
			pend_l_q <= (state_q == S_SUM) && (idx_q < DEPTH_C) && (idx_q < cnt_l_q);
			pend_r_q <= (state_q == S_SUM) && (idx_q < DEPTH_C) && (idx_q < cnt_r_q);
			if (pend_l_q && (rd_l[2*XW-1:XW] != '0)) begin
				st_l_q <= st_l_q + SW'(rd_l[2*XW-1:XW]);
				sb_l_q <= sb_l_q + SW'(rd_l[XW-1:0]);
				n_l_q  <= n_l_q + 1'b1;
			end
			if (pend_r_q && (rd_r[2*XW-1:XW] != '0)) begin
				st_r_q <= st_r_q + SW'(rd_r[2*XW-1:XW]);
				sb_r_q <= sb_r_q + SW'(rd_r[XW-1:0]);
				n_r_q  <= n_r_q + 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (lanes.valid) begin
						in_q    <= lanes.data;
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (left_on) begin
						ptr_l_q <= (ptr_l_q == LAST_A) ? '0 : ptr_l_q + 1'b1;
						if (cnt_l_q != DEPTH_C) cnt_l_q <= cnt_l_q + 1'b1;
					end
					if (right_on) begin
						ptr_r_q <= (ptr_r_q == LAST_A) ? '0 : ptr_r_q + 1'b1;
						if (cnt_r_q != DEPTH_C) cnt_r_q <= cnt_r_q + 1'b1;
					end
					miss_q <= miss_nx;
					if (ended) begin
						long_miss_q <= 1'b0;
						show_q      <= 1'b0;
						clear_q     <= 1'b0;
					end else if (miss_nx >= DEPTH_C) begin
						long_miss_q <= 1'b1;
						show_q      <= 1'b0;
						clear_q     <= 1'b1;
					end else begin
						show_q      <= 1'b1;
						clear_q     <= 1'b0;
					end
					st_l_q  <= '0;
					sb_l_q  <= '0;
					n_l_q   <= '0;
					st_r_q  <= '0;
					sb_r_q  <= '0;
					n_r_q   <= '0;
					idx_q   <= '0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					// a final pass with idx at the depth drains the last read
					if (idx_q == DEPTH_C) begin
						div_idx_q <= '0;
						state_q   <= S_DLOAD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DLOAD: begin
					if (dvs_sel == '0) begin
						avg_q[div_idx_q] <= '0;
						div_idx_q        <= div_idx_q + 1'b1;
						if (div_idx_q == 2'd3) state_q <= S_DONE;
					end else begin
						quo_q   <= dvd_sel;
						rem_q   <= '0;
						dvs_q   <= dvs_sel;
						bit_q   <= BW'(SW - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					quo_q <= quo_nx;
					rem_q <= rem_nx;
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						avg_q[div_idx_q] <= quo_nx[XW-1:0];
						div_idx_q        <= div_idx_q + 1'b1;
						state_q          <= (div_idx_q == 2'd3) ? S_DONE : S_DLOAD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_q.show_lanes       <= show_q;
						out_q.history_cleared  <= clear_q;
						out_q.avg_left_top     <= avg_q[0];
						out_q.avg_left_bottom  <= avg_q[1];
						out_q.avg_right_top    <= avg_q[2];
						out_q.avg_right_bottom <= avg_q[3];
						out_vld_q              <= 1'b1;
						if (clear_q) begin
							cnt_l_q <= '0;
							cnt_r_q <= '0;
							ptr_l_q <= '0;
							ptr_r_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_l_q <= DEPTH_C) && (cnt_r_q <= DEPTH_C))
		else $error("history fill count past depth");

	a_long_miss_sat: assert property (@(posedge clk) disable iff (!arst_n)
		long_miss_q |-> (miss_q == DEPTH_C))
		else $error("long miss set without saturated miss count");

	a_clear_applied: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && out_free && clear_q) |=> ((cnt_l_q == '0) && (cnt_r_q == '0)))
		else $error("histories not emptied after long miss");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < dvs_q))
		else $error("divider remainder not below divisor");

	a_cleared_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && out_free && clear_q) |=> !out_q.show_lanes)
		else $error("cleared frame marked as shown");

endmodule

// File: hdl/lps_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lps_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sim/tb_lane_position_smoother_core.sv
// Testbench for lane_position_smoother_core: directed frame table, then random bursts,
// every result checked against a built-in smoother model or a hand-typed result, with random stalls on both sides.
// Depends on lps_pkg, lps_stream_if and the core under hdl/.
module tb_lane_position_smoother_core;
	import lps_pkg::*;

	localparam int DEPTH        = 8;
	localparam int RANDOM_ITEMS = 730;
	localparam int QUIET_LIMIT  = 2000;  // cycles with no item moving on either side
	localparam int TAIL_CYCLES  = 100;   // cycles run on after the last result

	typedef struct {
		lps_in_t  frame;
		bit       known;   // result typed in by hand
		lps_out_t result;
	} frame_row_t;

	logic clk;
	logic arst_n;

	lps_stream_if #(.T(lps_in_t))  lanes_ch ();
	lps_stream_if #(.T(lps_out_t)) smoothed_ch ();

	lane_position_smoother_core #(.HISTORY_DEPTH(DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.lanes    (lanes_ch),
		.smoothed (smoothed_ch)
	);

	frame_row_t    plan[$];
	lps_out_t      expected[$];
	int            errors = 0;
	int            quiet_cycles = 0;
	int            dir_count;
	bit            steady = 1'b0;

	// smoother model state; index 0 is the left side, 1 the right
	logic [XW-1:0] hist_top[2][DEPTH];
	logic [XW-1:0] hist_bot[2][DEPTH];
	int            miss_count;
	bit            long_miss;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	function automatic lps_out_t smooth_frame(lps_in_t f);
		lps_out_t      o;
		logic [XW-1:0] top[2];
		logic [XW-1:0] bot[2];
		logic [XW-1:0] avg_t[2];
		logic [XW-1:0] avg_b[2];
		bit            on[2];
		bit            ended;
		int            st, sb, n, s, i;
		top[0] = f.left_top_x;
		bot[0] = f.left_bottom_x;
		top[1] = f.right_top_x;
		bot[1] = f.right_bottom_x;
		o.show_lanes      = 1'b1;
		o.history_cleared = 1'b0;
		ended = 1'b0;
		for (s = 0; s < 2; s++) begin
			on[s] = (top[s] != '0) || (bot[s] != '0);
			if (on[s]) begin
				for (i = DEPTH - 1; i >= 1; i--) begin
					hist_top[s][i] = hist_top[s][i-1];
					hist_bot[s][i] = hist_bot[s][i-1];
				end
				hist_top[s][0] = top[s];
				hist_bot[s][0] = bot[s];
			end
			st = 0;
			sb = 0;
			n  = 0;
			// entries with a zero top drop out of both sums
			for (i = 0; i < DEPTH; i++) begin
				if (hist_top[s][i] != '0) begin
					st += hist_top[s][i];
					sb += hist_bot[s][i];
					n++;
				end
			end
			avg_t[s] = (n == 0) ? '0 : XW'(st / n);
			avg_b[s] = (n == 0) ? '0 : XW'(sb / n);
		end
		o.avg_left_top     = avg_t[0];
		o.avg_left_bottom  = avg_b[0];
		o.avg_right_top    = avg_t[1];
		o.avg_right_bottom = avg_b[1];
		if (on[0] && on[1]) begin
			miss_count = 0;
			if (long_miss) begin
				long_miss    = 1'b0;
				o.show_lanes = 1'b0;
				ended        = 1'b1;
			end
		end else if (!on[0] && !on[1]) begin
			if (miss_count < DEPTH) miss_count++;
		end
		if (!ended && miss_count >= DEPTH) begin
			long_miss = 1'b1;
			for (s = 0; s < 2; s++) begin
				for (i = 0; i < DEPTH; i++) begin
					hist_top[s][i] = '0;
					hist_bot[s][i] = '0;
				end
			end
			o.history_cleared = 1'b1;
			o.show_lanes      = 1'b0;
		end
		return o;
	endfunction

	task automatic add_frame(input logic [XW-1:0] lt, lb, rt, rb);
		frame_row_t r;
		r.frame  = '{lt, lb, rt, rb};
		r.known  = 1'b0;
		r.result = '0;
		plan.push_back(r);
	endtask

	task automatic add_known(input logic [XW-1:0] lt, lb, rt, rb, input bit show, clr,
			input logic [XW-1:0] alt, alb, art, arb);
		frame_row_t r;
		r.frame  = '{lt, lb, rt, rb};
		r.known  = 1'b1;
		r.result = '{show, clr, alt, alb, art, arb};
		plan.push_back(r);
	endtask

	function automatic logic [XW-1:0] rand_x();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return XW'(1);
			default: return XW'($urandom_range(1, 4095));
		endcase
	endfunction

	// {top, bottom} of one lane; a present lane has at least one nonzero coordinate
	function automatic logic [2*XW-1:0] lane_pair(bit present);
		logic [XW-1:0] t, b;
		if (!present) return '0;
		t = rand_x();
		b = rand_x();
		if (t == '0 && b == '0) b = XW'($urandom_range(1, 4095));
		return {t, b};
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("mismatch %s at %0t: got %0d want %0d", field, $realtime, got, want);
		errors++;
	endtask

	task automatic build_plan();
		logic [XW-1:0] lt, lb, rt, rb;
		int            kind, len, k;
		add_known(100, 200, 300, 400, 1, 0, 100, 200, 300, 400);
		add_frame(4095, 4095, 4095, 4095);
		add_frame(0, 0, 0, 0);
		add_frame(0, 4095, 0, 0);        // left only, zero top kept out of the mean
		add_frame(0, 0, 4095, 0);        // right only
		add_frame(1, 1, 1, 1);           // both present, miss run restarts
		repeat (8) add_frame(0, 0, 0, 0); // last one hits the miss limit
		add_known(0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		add_known(5, 6, 0, 0, 0, 1, 5, 6, 0, 0);       // one lane at the limit clears again
		add_known(7, 8, 9, 10, 0, 0, 7, 8, 9, 10);     // long miss drops, frame hidden
		repeat (7) add_frame(4095, 4095, 4095, 4095);
		add_known(4095, 4095, 4095, 4095, 1, 0, 4095, 4095, 4095, 4095);
		dir_count = plan.size();

		while (plan.size() < dir_count + RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 40)      len = $urandom_range(1, 12);
			else if (kind < 65) len = $urandom_range(1, 12);
			else if (kind < 85) len = $urandom_range(1, 4);
			else                len = $urandom_range(1, 3);
			for (k = 0; k < len; k++) begin
				if (kind < 40) begin
					{lt, lb} = lane_pair(1);
					{rt, rb} = lane_pair(1);
				end else if (kind < 65) begin
					{lt, lb, rt, rb} = '0;
				end else if (kind < 85) begin
					if ($urandom_range(0, 1)) begin
						{lt, lb} = lane_pair(1);
						{rt, rb} = '0;
					end else begin
						{lt, lb} = '0;
						{rt, rb} = lane_pair(1);
					end
				end else begin
					lt = $urandom_range(0, 3) == 0 ? '0 : XW'($urandom());
					lb = $urandom_range(0, 3) == 0 ? '0 : XW'($urandom());
					rt = $urandom_range(0, 3) == 0 ? '0 : XW'($urandom());
					rb = $urandom_range(0, 3) == 0 ? '0 : XW'($urandom());
				end
				add_frame(lt, lb, rt, rb);
			end
		end
	endtask

	initial begin : feeder
		int       idx, gap, s, i;
		lps_out_t pred;
		lanes_ch.valid = 1'b0;
		lanes_ch.data  = '0;
		for (s = 0; s < 2; s++) begin
			for (i = 0; i < DEPTH; i++) begin
				hist_top[s][i] = '0;
				hist_bot[s][i] = '0;
			end
		end
		miss_count = 0;
		long_miss  = 1'b0;
		build_plan();
		wait (arst_n === 1'b1);
		for (idx = 0; idx < plan.size(); idx++) begin
			if (idx == dir_count || idx == dir_count + 350) begin
				// hold off until the block has handed back everything
				@(negedge clk);
				lanes_ch.valid <= 1'b0;
				while (expected.size() != 0) @(negedge clk);
			end
			steady = (idx >= dir_count + 400 && idx < dir_count + 480);
			gap = pick_gap();
			repeat (gap) begin
				@(negedge clk);
				lanes_ch.valid <= 1'b0;
			end
			@(negedge clk);
			lanes_ch.valid <= 1'b1;
			lanes_ch.data  <= plan[idx].frame;
			do @(posedge clk); while (!lanes_ch.ready);
			pred = smooth_frame(plan[idx].frame);
			expected.push_back(plan[idx].known ? plan[idx].result : pred);
		end
		@(negedge clk);
		lanes_ch.valid <= 1'b0;
		while (expected.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	initial begin : result_sink
		int stall;
		smoothed_ch.ready = 1'b0;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				smoothed_ch.ready <= 1'b0;
				stall--;
			end else begin
				smoothed_ch.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : result_check
		lps_out_t want;
		lps_out_t got;
		if (arst_n && smoothed_ch.valid && smoothed_ch.ready) begin
			got = smoothed_ch.data;
			if (expected.size() == 0) begin
				report_mismatch("unexpected item", 1, 0);
			end else begin
				want = expected.pop_front();
				if (got.show_lanes !== want.show_lanes)
					report_mismatch("show_lanes", got.show_lanes, want.show_lanes);
				if (got.history_cleared !== want.history_cleared)
					report_mismatch("history_cleared", got.history_cleared,
						want.history_cleared);
				if (got.avg_left_top !== want.avg_left_top)
					report_mismatch("avg_left_top", got.avg_left_top, want.avg_left_top);
				if (got.avg_left_bottom !== want.avg_left_bottom)
					report_mismatch("avg_left_bottom", got.avg_left_bottom,
						want.avg_left_bottom);
				if (got.avg_right_top !== want.avg_right_top)
					report_mismatch("avg_right_top", got.avg_right_top, want.avg_right_top);
				if (got.avg_right_bottom !== want.avg_right_bottom)
					report_mismatch("avg_right_bottom", got.avg_right_bottom,
						want.avg_right_bottom);
			end
		end
	end

	always @(posedge clk) begin
		if ((lanes_ch.valid && lanes_ch.ready) || (smoothed_ch.valid && smoothed_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
